>>> rtl/core/slp_pkg.sv
// Package for the status line parser: shared constants, character codes,
// number-parse phase codes and the structs passed between submodules.
// No dependencies.
package slp_pkg;

    localparam int LINE_CAPACITY = 32;
    localparam int LEN_W         = $clog2(LINE_CAPACITY);
    localparam logic [LEN_W-1:0] LEN_LAST = LEN_W'(LINE_CAPACITY - 1);

    localparam int HEAD_LEN = 5;
    localparam logic [LEN_W-1:0] LEN_HEAD = LEN_W'(HEAD_LEN);

    localparam int LIMIT_W = 16;
    localparam logic [LIMIT_W-1:0] STALE_LIMIT_RESET = 16'd3000;

    localparam int IDLE_W = 17;
    localparam logic [IDLE_W-1:0] IDLE_MAX = '1;

    // magnitude in thousandths, saturates at 2^31-1
    localparam int MAG_W = 31;
    localparam logic [MAG_W-1:0] MAG_MAX = '1;

    localparam int POS_W = 32;

    // number-parse phases
    localparam logic [2:0] PH_BLANKS    = 3'd0;
    localparam logic [2:0] PH_SIGNED    = 3'd1;
    localparam logic [2:0] PH_INT       = 3'd2;
    localparam logic [2:0] PH_DOT_ONLY  = 3'd3;
    localparam logic [2:0] PH_FRAC      = 3'd4;
    localparam logic [2:0] PH_DONE_NUM  = 3'd5;
    localparam logic [2:0] PH_DONE_NONE = 3'd6;

    // characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;

    // "STAT:" header, one character per position
    function automatic logic [7:0] head_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h53;
            3'd1:    ch = 8'h54;
            3'd2:    ch = 8'h41;
            3'd3:    ch = 8'h54;
            3'd4:    ch = CH_COLON;
            default: ch = CH_NUL;
        endcase
        return ch;
    endfunction

    typedef struct packed {
        logic             valid;
        logic             connected;
        logic [POS_W-1:0] position;
    } frame_evt_t;

    typedef struct packed {
        logic             valid;
        logic             connected;
        logic [POS_W-1:0] position_um;
        logic             cause;
    } result_t;

endpackage

>>> rtl/core/slp_ifs.sv
// Valid/ready channel interfaces for the status line parser.
// Depends on slp_pkg.
interface slp_item_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] rx_byte;

    modport source (output valid, cmd, rx_byte, input ready);
    modport sink   (input valid, cmd, rx_byte, output ready);
endinterface

interface slp_result_if;
    logic                             valid;
    logic                             ready;
    logic                             connected;
    logic signed [slp_pkg::POS_W-1:0] position_um;
    logic                             cause;

    modport source (output valid, connected, position_um, cause, input ready);
    modport sink   (input valid, connected, position_um, cause, output ready);
endinterface

>>> rtl/core/slp_num_step.sv
// One character step of the decimal number scanner (blanks, sign, digits,
// fraction), magnitude in saturated thousandths. Depends on slp_pkg.
module slp_num_step (
    input  logic [2:0]                phase,
    input  logic                      negative,
    input  logic [slp_pkg::MAG_W-1:0] accum,
    input  logic [1:0]                frac_cnt,
    input  logic [7:0]                ch,
    output logic [2:0]                phase_next,
    output logic                      negative_next,
    output logic [slp_pkg::MAG_W-1:0] accum_next,
    output logic [1:0]                frac_cnt_next
);

    logic                      is_digit;
    logic                      is_blank;
    logic                      is_sign;
    logic [3:0]                digit;
    logic [34:0]               scaled;
    logic [31:0]               frac_sum;
    logic [9:0]                frac_weight;
    logic [2:0]                int_phase;
    logic [slp_pkg::MAG_W-1:0] int_accum;
    logic [2:0]                fr_phase;
    logic [slp_pkg::MAG_W-1:0] fr_accum;
    logic [1:0]                fr_cnt;
    logic                      was_int;
    logic                      was_frac;

    assign is_digit = (ch >= slp_pkg::CH_ZERO) && (ch <= slp_pkg::CH_NINE);
    assign is_blank = (ch == slp_pkg::CH_SPACE) || (ch == slp_pkg::CH_TAB) ||
                      (ch == slp_pkg::CH_VT) || (ch == slp_pkg::CH_FF);
    assign is_sign  = (ch == slp_pkg::CH_PLUS) || (ch == slp_pkg::CH_MINUS);
    assign digit    = is_digit ? 4'(ch - slp_pkg::CH_ZERO) : 4'd0;

    // accum*10 + digit*1000 as shifts and adds
    assign scaled = ({4'd0, accum} << 3) + ({4'd0, accum} << 1) + 35'(digit) * 35'd1000;

    always_comb
    begin
        case (frac_cnt)
            2'd0:    frac_weight = 10'd100;
            2'd1:    frac_weight = 10'd10;
            default: frac_weight = 10'd1;
        endcase
    end

    assign frac_sum = {1'b0, accum} + 32'(frac_weight) * 32'(digit);

    assign was_int  = (phase == slp_pkg::PH_INT);
    assign was_frac = (phase == slp_pkg::PH_FRAC);

    // integer part, also taken from the blank phase on a non-blank non-sign
    always_comb
    begin
        int_accum = accum;
        if (is_digit)
        begin
            int_phase = slp_pkg::PH_INT;
            int_accum = (scaled > 35'(slp_pkg::MAG_MAX)) ? slp_pkg::MAG_MAX
                                                         : scaled[slp_pkg::MAG_W-1:0];
        end
        else if (ch == slp_pkg::CH_DOT)
        begin
            int_phase = was_int ? slp_pkg::PH_FRAC : slp_pkg::PH_DOT_ONLY;
        end
        else
        begin
            int_phase = was_int ? slp_pkg::PH_DONE_NUM : slp_pkg::PH_DONE_NONE;
        end
    end

    // fraction part, digits beyond the third dropped
    always_comb
    begin
        fr_accum = accum;
        fr_cnt   = frac_cnt;
        if (is_digit)
        begin
            fr_phase = slp_pkg::PH_FRAC;
            if (frac_cnt != 2'd3)
            begin
                fr_accum = (frac_sum > 32'(slp_pkg::MAG_MAX)) ? slp_pkg::MAG_MAX
                                                              : frac_sum[slp_pkg::MAG_W-1:0];
                fr_cnt   = frac_cnt + 2'd1;
            end
        end
        else
        begin
            fr_phase = was_frac ? slp_pkg::PH_DONE_NUM : slp_pkg::PH_DONE_NONE;
        end
    end

    always_comb
    begin
        phase_next    = phase;
        negative_next = negative;
        accum_next    = accum;
        frac_cnt_next = frac_cnt;
        case (phase)
            slp_pkg::PH_BLANKS:
            begin
                if (is_blank)
                begin
                    phase_next = phase;
                end
                else if (is_sign)
                begin
                    negative_next = (ch == slp_pkg::CH_MINUS);
                    phase_next    = slp_pkg::PH_SIGNED;
                end
                else
                begin
                    phase_next = int_phase;
                    accum_next = int_accum;
                end
            end
            slp_pkg::PH_SIGNED, slp_pkg::PH_INT:
            begin
                phase_next = int_phase;
                accum_next = int_accum;
            end
            slp_pkg::PH_DOT_ONLY, slp_pkg::PH_FRAC:
            begin
                phase_next    = fr_phase;
                accum_next    = fr_accum;
                frac_cnt_next = fr_cnt;
            end
            default:
            begin
                phase_next = phase;
            end
        endcase
    end

endmodule

>>> rtl/core/slp_line_parser.sv
// Line assembly and frame recognition: header check, link flag, separator,
// number scan; reports a frame on CR/LF. Depends on slp_pkg, slp_num_step.
module slp_line_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step_en,
    input  logic [7:0]          step_byte,
    output slp_pkg::frame_evt_t frame
);

    logic [slp_pkg::LEN_W-1:0] line_length_reg, line_length_next;
    logic                      prefix_ok_reg, prefix_ok_next;
    logic                      text_ended_reg, text_ended_next;
    logic                      link_flag_seen_reg, link_flag_seen_next;
    logic                      separator_seen_reg, separator_seen_next;
    logic [2:0]                number_phase_reg, number_phase_next;
    logic                      number_negative_reg, number_negative_next;
    logic [slp_pkg::MAG_W-1:0] number_accum_reg, number_accum_next;
    logic [1:0]                fraction_digits_reg, fraction_digits_next;

    logic [2:0]                ns_phase;
    logic                      ns_negative;
    logic [slp_pkg::MAG_W-1:0] ns_accum;
    logic [1:0]                ns_frac_cnt;

    logic                      is_eol;
    logic                      in_head;
    logic                      has_number;
    logic [slp_pkg::POS_W-1:0] magnitude;

    slp_num_step u_num_step (
        .phase         (number_phase_reg),
        .negative      (number_negative_reg),
        .accum         (number_accum_reg),
        .frac_cnt      (fraction_digits_reg),
        .ch            (step_byte),
        .phase_next    (ns_phase),
        .negative_next (ns_negative),
        .accum_next    (ns_accum),
        .frac_cnt_next (ns_frac_cnt)
    );

    assign is_eol     = (step_byte == slp_pkg::CH_LF) || (step_byte == slp_pkg::CH_CR);
    assign in_head    = (line_length_reg < slp_pkg::LEN_HEAD);
    assign has_number = (number_phase_reg == slp_pkg::PH_INT) ||
                        (number_phase_reg == slp_pkg::PH_FRAC) ||
                        (number_phase_reg == slp_pkg::PH_DONE_NUM);
    assign magnitude  = {1'b0, number_accum_reg};

    always_comb
    begin
        frame.valid     = step_en && is_eol && (line_length_reg != '0) && prefix_ok_reg &&
                          (line_length_reg >= slp_pkg::LEN_HEAD) && separator_seen_reg;
        frame.connected = link_flag_seen_reg;
        if (!has_number)
        begin
            frame.position = '0;
        end
        else if (number_negative_reg)
        begin
            frame.position = -magnitude;
        end
        else
        begin
            frame.position = magnitude;
        end
    end

    always_comb
    begin
        line_length_next     = line_length_reg;
        prefix_ok_next       = prefix_ok_reg;
        text_ended_next      = text_ended_reg;
        link_flag_seen_next  = link_flag_seen_reg;
        separator_seen_next  = separator_seen_reg;
        number_phase_next    = number_phase_reg;
        number_negative_next = number_negative_reg;
        number_accum_next    = number_accum_reg;
        fraction_digits_next = fraction_digits_reg;

        // restart on a non-empty line end, or on overflow
        if (step_en && ((is_eol && (line_length_reg != '0)) ||
                        (!is_eol && (line_length_reg == slp_pkg::LEN_LAST))))
        begin
            line_length_next     = '0;
            prefix_ok_next       = 1'b1;
            text_ended_next      = 1'b0;
            link_flag_seen_next  = 1'b0;
            separator_seen_next  = 1'b0;
            number_phase_next    = slp_pkg::PH_BLANKS;
            number_negative_next = 1'b0;
            number_accum_next    = '0;
            fraction_digits_next = '0;
        end
        else if (step_en && !is_eol)
        begin
            line_length_next = line_length_reg + 1'b1;
            if (!text_ended_reg)
            begin
                if (step_byte == slp_pkg::CH_NUL)
                begin
                    text_ended_next = 1'b1;
                    if (in_head)
                    begin
                        prefix_ok_next = 1'b0;
                    end
                end
                else if (in_head)
                begin
                    if (step_byte != slp_pkg::head_char(line_length_reg[2:0]))
                    begin
                        prefix_ok_next = 1'b0;
                    end
                end
                else
                begin
                    if (line_length_reg == slp_pkg::LEN_HEAD)
                    begin
                        link_flag_seen_next = (step_byte == slp_pkg::CH_ONE);
                    end
                    if (!separator_seen_reg)
                    begin
                        if (step_byte == slp_pkg::CH_COLON)
                        begin
                            separator_seen_next = 1'b1;
                        end
                    end
                    else
                    begin
                        number_phase_next    = ns_phase;
                        number_negative_next = ns_negative;
                        number_accum_next    = ns_accum;
                        fraction_digits_next = ns_frac_cnt;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_length_reg     <= '0;
            prefix_ok_reg       <= 1'b1;
            text_ended_reg      <= 1'b0;
            link_flag_seen_reg  <= 1'b0;
            separator_seen_reg  <= 1'b0;
            number_phase_reg    <= slp_pkg::PH_BLANKS;
            number_negative_reg <= 1'b0;
            number_accum_reg    <= '0;
            fraction_digits_reg <= '0;
        end
        else
        begin
            line_length_reg     <= line_length_next;
            prefix_ok_reg       <= prefix_ok_next;
            text_ended_reg      <= text_ended_next;
            link_flag_seen_reg  <= link_flag_seen_next;
            separator_seen_reg  <= separator_seen_next;
            number_phase_reg    <= number_phase_next;
            number_negative_reg <= number_negative_next;
            number_accum_reg    <= number_accum_next;
            fraction_digits_reg <= fraction_digits_next;
        end
    end

endmodule

>>> rtl/core/slp_link_timer.sv
// Link staleness timer and result selection: frame results, one timeout
// result per silent period. Depends on slp_pkg.
module slp_link_timer (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step_en,
    input  logic                        tick,
    input  slp_pkg::frame_evt_t         frame,
    input  logic [slp_pkg::LIMIT_W-1:0] stale_limit,
    output slp_pkg::result_t            res
);

    logic [slp_pkg::IDLE_W-1:0] idle_ticks_reg, idle_ticks_next;
    logic                       stale_reported_reg, stale_reported_next;
    logic [slp_pkg::POS_W-1:0]  last_position_reg, last_position_next;
    logic [slp_pkg::IDLE_W-1:0] idle_inc;
    logic                       fire;

    assign idle_inc = (idle_ticks_reg == slp_pkg::IDLE_MAX) ? idle_ticks_reg
                                                            : idle_ticks_reg + 1'b1;
    assign fire     = step_en && tick && !stale_reported_reg &&
                      (idle_inc > slp_pkg::IDLE_W'(stale_limit));

    always_comb
    begin
        res.valid = frame.valid || fire;
        if (frame.valid)
        begin
            res.connected   = frame.connected;
            res.position_um = frame.position;
            res.cause       = 1'b0;
        end
        else
        begin
            res.connected   = 1'b0;
            res.position_um = last_position_reg;
            res.cause       = 1'b1;
        end
    end

    always_comb
    begin
        idle_ticks_next     = idle_ticks_reg;
        stale_reported_next = stale_reported_reg;
        last_position_next  = last_position_reg;
        if (step_en && tick)
        begin
            idle_ticks_next = idle_inc;
            if (fire)
            begin
                stale_reported_next = 1'b1;
            end
        end
        else if (frame.valid)
        begin
            idle_ticks_next     = '0;
            stale_reported_next = 1'b0;
            last_position_next  = frame.position;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_ticks_reg     <= '0;
            stale_reported_reg <= 1'b0;
            last_position_reg  <= '0;
        end
        else
        begin
            idle_ticks_reg     <= idle_ticks_next;
            stale_reported_reg <= stale_reported_next;
            last_position_reg  <= last_position_next;
        end
    end

endmodule

>>> rtl/core/status_line_parser_with_link_timeout.sv
// Status line parser with link timeout: input word register, line parser,
// link timer and result register. Depends on slp_pkg, slp_ifs,
// slp_line_parser, slp_link_timer.
//
// Usage:
//   item   - valid/ready words: cmd 0 carries a received byte in rx_byte,
//            cmd 1 is one time tick.
//   result - valid/ready words {connected, position_um, cause}; at most one
//            per input word. A status frame ends on CR/LF and gives cause 0;
//            a staleness timeout gives cause 1 with the last position.
//   cfg_wr_en/cfg_wr_data - write the stale limit in ticks (reset 3000);
//            write only while no word is in flight.
// Timing: a taken word sits in the input register; when it produces a result,
// that result is loaded into the result register as the word advances. One
// word per cycle is taken when the result side keeps up; parsing is one short
// pass per byte (a times-ten via shifts and adds) between the two registers.
// Stall: while the result register holds an untaken word, the input register
// holds its word and ready drops once both are full; nothing is lost.
// Reset: clears all line state, the idle counter and the limit to 3000.
module status_line_parser_with_link_timeout (
    input  logic                                 clk,
    input  logic                                 rst_n,
    slp_item_if.sink                             item,
    slp_result_if.source                         result,
    input  logic                                 cfg_wr_en,
    input  logic [slp_pkg::LIMIT_W-1:0]          cfg_wr_data
);

    logic                        in_valid_reg;
    logic                        in_cmd_reg;
    logic [7:0]                  in_byte_reg;
    logic                        out_valid_reg;
    logic                        out_connected_reg;
    logic [slp_pkg::POS_W-1:0]   out_position_reg;
    logic                        out_cause_reg;
    logic [slp_pkg::LIMIT_W-1:0] stale_limit_reg;

    logic                        advance;
    logic                        take;
    slp_pkg::frame_evt_t         frame;
    slp_pkg::result_t            res;

    assign advance    = in_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !in_valid_reg || advance;
    assign take       = item.valid && item.ready;

    slp_line_parser u_line_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (advance && !in_cmd_reg),
        .step_byte (in_byte_reg),
        .frame     (frame)
    );

    slp_link_timer u_link_timer (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_en     (advance),
        .tick        (in_cmd_reg),
        .frame       (frame),
        .stale_limit (stale_limit_reg),
        .res         (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            stale_limit_reg <= slp_pkg::STALE_LIMIT_RESET;
        end
        else
        begin
            if (take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance && res.valid)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_wr_en)
            begin
                stale_limit_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_cmd_reg  <= item.cmd;
            in_byte_reg <= item.rx_byte;
        end
        if (advance && res.valid)
        begin
            out_connected_reg <= res.connected;
            out_position_reg  <= res.position_um;
            out_cause_reg     <= res.cause;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.connected   = out_connected_reg;
    assign result.position_um = out_position_reg;
    assign result.cause       = out_cause_reg;

endmodule
